// File: hdl/otq_pkg.sv
// ----------------------------------------------------------------------------
// otq_pkg
// shared constants, request kinds and controller/datapath interface types
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_ID_W  = 4;
    localparam int DELAY_W    = 31;
    localparam int TICK_W     = 32;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic idx_clr;    // restart the queue scan
        logic idx_inc;    // step the queue scan
        logic remove;     // unlink queue entry at scan index
        logic insert;     // link request slot at scan index
        logic fire;       // unlink queue head and hold it as pending firing
        logic emit;       // move pending firing to the output register
        logic emit_last;  // emitted firing is the final one of this tick
    } otq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        kind_t kind;
        logic  slot_ok;
        logic  armed;
        logic  find_hit;
        logic  scan_stop;
        logic  head_fires;
        logic  pend_valid;
        logic  out_free;
    } otq_status_t;

    // wrap-safe ordering: a lies before b
    function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                         input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return diff[TICK_W-1];
    endfunction

endpackage

// File: hdl/otq_datapath.sv
// ----------------------------------------------------------------------------
// otq_datapath
// tick counter, slot state, sorted expiry queue and output register
// ----------------------------------------------------------------------------
module otq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [otq_pkg::KIND_W-1:0]      kind,
    input  logic [otq_pkg::SLOT_ID_W-1:0]   slot_id,
    input  logic [otq_pkg::DELAY_W-1:0]     delay,
    input  otq_pkg::otq_cmd_t               cmd,
    output otq_pkg::otq_status_t            status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [otq_pkg::SLOT_ID_W-1:0]   fired_slot,
    output logic                            last
);
    import otq_pkg::*;

    // control state
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [SLOT_COUNT-1:0] armed_reg, armed_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // payload state
    kind_t                 kind_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic                  slot_ok_reg;
    logic [TICK_W-1:0]     expire_reg;
    logic [TICK_W-1:0]     expiry_mem [SLOT_COUNT];
    logic [IDX_W-1:0]      order_reg  [SLOT_COUNT];
    logic [IDX_W-1:0]      order_next [SLOT_COUNT];
    logic [IDX_W-1:0]      shift_up   [SLOT_COUNT];
    logic [IDX_W-1:0]      shift_dn   [SLOT_COUNT];
    logic [IDX_W-1:0]      pend_slot_reg;
    logic [SLOT_ID_W-1:0]  fired_slot_reg;
    logic                  last_reg;

    logic [IDX_W-1:0]      scan_idx;
    logic [IDX_W-1:0]      order_rd;
    logic [TICK_W-1:0]     expiry_rd;
    logic                  unlink;
    logic                  out_free;

    assign scan_idx  = idx_reg[IDX_W-1:0];
    assign order_rd  = order_reg[scan_idx];
    assign expiry_rd = expiry_mem[order_rd];
    assign unlink    = cmd.remove | cmd.fire;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.kind       = kind_reg;
        status.slot_ok    = slot_ok_reg;
        status.armed      = armed_reg[slot_reg];
        status.find_hit   = (order_rd == slot_reg);
        status.scan_stop  = (idx_reg == len_reg) || tick_before(expire_reg, expiry_rd);
        status.head_fires = (len_reg != '0) && !tick_before(tick_reg, expiry_rd);
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    // neighbor views of the queue for one-step shifts
    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT - 1; j++)
        begin
            shift_up[j] = order_reg[j + 1];
        end
        shift_up[SLOT_COUNT-1] = order_reg[SLOT_COUNT-1];
        shift_dn[0] = order_reg[0];
        for (int j = 1; j < SLOT_COUNT; j++)
        begin
            shift_dn[j] = order_reg[j - 1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            order_next[j] = order_reg[j];
            if (unlink && (IDX_W'(j) >= scan_idx))
            begin
                order_next[j] = shift_up[j];
            end
            else if (cmd.insert && (IDX_W'(j) == scan_idx))
            begin
                order_next[j] = slot_reg;
            end
            else if (cmd.insert && (IDX_W'(j) > scan_idx))
            begin
                order_next[j] = shift_dn[j];
            end
        end
    end

    always_comb
    begin
        tick_next       = tick_reg;
        armed_next      = armed_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.load && (kind_t'(kind) == KIND_TICK))
        begin
            tick_next = tick_reg + TICK_W'(1);
        end

        if (cmd.load || cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        if (unlink)
        begin
            armed_next[order_rd] = 1'b0;
            len_next             = len_reg - CNT_W'(1);
        end
        else if (cmd.insert)
        begin
            armed_next[slot_reg] = 1'b1;
            len_next             = len_reg + CNT_W'(1);
        end

        if (cmd.fire)
        begin
            pend_valid_next = 1'b1;
        end
        else if (cmd.emit && cmd.emit_last)
        begin
            pend_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            armed_reg      <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            armed_reg      <= armed_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind_t'(kind);
            slot_reg    <= IDX_W'(slot_id);
            slot_ok_reg <= (32'(slot_id) < SLOT_COUNT);
            expire_reg  <= tick_reg + TICK_W'(delay);
        end
        if (cmd.insert)
        begin
            expiry_mem[slot_reg] <= expire_reg;
        end
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            order_reg[j] <= order_next[j];
        end
        if (cmd.fire)
        begin
            pend_slot_reg <= order_rd;
        end
        if (cmd.emit)
        begin
            fired_slot_reg <= SLOT_ID_W'(pend_slot_reg);
            last_reg       <= cmd.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired_slot = fired_slot_reg;
    assign last       = last_reg;

    // queue length always tracks the armed slots
    a_len_matches_armed: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(armed_reg) == int'(len_reg))
        else $error("queue length differs from armed slot count");

    // the output register is never overwritten while a firing waits
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("firing emitted into a stalled output register");

    // tick counter only holds or advances by one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((tick_reg == $past(tick_reg)) ||
                  (tick_reg == $past(tick_reg) + TICK_W'(1))))
        else $error("tick counter jumped");

    // a firing is only unlinked from an armed head
    a_fire_armed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (armed_reg[order_rd] && (idx_reg == '0)))
        else $error("fired a slot that is not the armed head");

endmodule

// File: hdl/otq_ctrl.sv
// ----------------------------------------------------------------------------
// otq_ctrl
// request sequencer: decode, queue search, insertion and tick firing
// ----------------------------------------------------------------------------
module otq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  otq_pkg::otq_status_t  status,
    output otq_pkg::otq_cmd_t     cmd
);
    import otq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_FIND   = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_HEAD   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.kind)
                    KIND_TICK:
                    begin
                        state_next = ST_HEAD;
                    end
                    KIND_START:
                    begin
                        if (!status.slot_ok)
                            state_next = ST_IDLE;
                        else if (status.armed)
                            state_next = ST_FIND;
                        else
                            state_next = ST_SCAN;
                    end
                    KIND_STOP:
                    begin
                        if (status.slot_ok && status.armed)
                            state_next = ST_FIND;
                        else
                            state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FIND:
            begin
                if (status.find_hit)
                begin
                    cmd.remove = 1'b1;
                    if (status.kind == KIND_START)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_stop)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_HEAD:
            begin
                if (status.head_fires)
                begin
                    // a held firing goes out first, it is not the last
                    if (!status.pend_valid || status.out_free)
                    begin
                        cmd.fire = 1'b1;
                        cmd.emit = status.pend_valid;
                    end
                end
                else if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// File: hdl/one_shot_timer_queue_core.sv
// ----------------------------------------------------------------------------
// one_shot_timer_queue_core
// one-shot timer slots kept in a queue sorted by expiry tick
// ----------------------------------------------------------------------------
// A request is a tick, a start or a stop. Start arms a slot to expire at the
// current tick plus delay (re-arming it if already armed); stop disarms it.
// A tick advances the 32-bit counter and then fires every queued slot whose
// expiry has been reached, head first, one result per slot, with last set on
// the final firing of that tick. Expiry compares by wrap-safe signed
// difference. Every request passes a decode step first. A tick then fires
// its due slots one after another, held back while the output stalls; a
// start walks past the queued slots that precede its insertion point, and a
// re-armed slot is first found and unlinked, walking past the queued slots
// ahead of it; a stop of an armed slot walks past the queued slots ahead of
// it; a stop of a stopped slot or an unused kind ends after decode. The
// single queue scan index steps one entry a cycle. A stalled output holds
// firings back but a new request is taken as soon as the previous one is
// finished, even with a result waiting.
// ----------------------------------------------------------------------------
module one_shot_timer_queue_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [otq_pkg::KIND_W-1:0]      kind,
    input  logic [otq_pkg::SLOT_ID_W-1:0]   slot_id,
    input  logic [otq_pkg::DELAY_W-1:0]     delay,
    // firing channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [otq_pkg::SLOT_ID_W-1:0]   fired_slot,
    output logic                            last
);
    import otq_pkg::*;

    // controller drives commands, datapath answers with status
    otq_cmd_t    cmd;
    otq_status_t status;

    // sequencer: one request at a time, walks the queue one entry a cycle
    otq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // slot state, sorted queue and the output register
    otq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .slot_id    (slot_id),
        .delay      (delay),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fired_slot (fired_slot),
        .last       (last)
    );

endmodule
